// ----- rtl/core/pif_pkg.sv -----
// Shared types and constants of the point-in-face test block.
`default_nettype none

package pif_pkg;

  localparam int PT_W        = 21;  // point coordinate field width
  localparam int TAG_W       = 16;
  localparam int REG_W       = 63;  // widest config register
  localparam int CNT_W       = 3;   // vertex_count register width
  localparam int NUM_VREGS   = 4;   // vertex registers in the register map
  localparam int CFG_IDX_W   = 3;
  localparam int NUM_STG     = 7;   // pipeline register stages

  localparam logic [CNT_W-1:0] VCOUNT_RST   = 3'd4;
  localparam logic [CNT_W-1:0] MIN_VERTICES = 3'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VERTEX_COUNT = 3'd0,
    CFG_VERTEX0      = 3'd1,
    CFG_VERTEX1      = 3'd2,
    CFG_VERTEX2      = 3'd3,
    CFG_VERTEX3      = 3'd4,
    CFG_NORMAL       = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0]                  vertex_count;
    logic [NUM_VREGS-1:0][REG_W-1:0]   vtx;
    logic [REG_W-1:0]                  normal;
  } cfg_t;

  // per-stage load enables from the pipeline control
  typedef struct packed {
    logic [NUM_STG-1:0] en;
  } stage_en_t;

endpackage

`default_nettype wire

// ----- rtl/core/pif_if.sv -----
// Input and result channel interfaces of the point-in-face test block.
`default_nettype none

interface pif_in_if import pif_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [PT_W-1:0]  point_x;
  logic signed [PT_W-1:0]  point_y;
  logic signed [PT_W-1:0]  point_z;
  logic [TAG_W-1:0]        node_tag;

  modport source (output valid, output point_x, output point_y, output point_z,
                  output node_tag, input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z,
                  input node_tag, output ready);
endinterface

interface pif_out_if import pif_pkg::*;;
  logic              valid;
  logic              ready;
  logic              inside_res;
  logic [TAG_W-1:0]  tag_out;

  modport source (output valid, output inside_res, output tag_out, input ready);
  modport sink   (input valid, input inside_res, input tag_out, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/point_in_face_test.sv -----
// Point-in-convex-face test: top level with pipeline control.
//
// Usage: write the vertex count, up to four vertices and the face normal on
// the cfg_ port (cfg_we, cfg_idx, cfg_wdata) while the block is idle. Each
// word on in_ch carries one query point and a node tag; out_ch returns one
// word per point with inside_res (inside or on the face) and the tag echoed.
// Both channels move a word when valid and ready are high at a clock edge.
// The datapath is a seven-stage register pipeline: vertex differences,
// partial products, cross terms, normal products, sums, per-edge sign, and
// the output register. Each point passes these stages in order, and one
// point is taken every cycle while out_ch does not stall; every stage
// loads a new word whenever it is empty or the next stage is ready.
// Every stage keeps its own valid bit, so a stalled out_ch holds the output
// word and the pipeline fills its bubbles; in_ch.ready drops only when all
// seven stages hold words. Synchronous reset (rst_n low) empties the
// pipeline and loads the registers with four vertices at the origin and a
// zero normal.
`default_nettype none

module point_in_face_test import pif_pkg::*; #(
  parameter int COORD_BITS   = 21,
  parameter int MAX_VERTICES = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pif_in_if.sink                in_ch,
  pif_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [REG_W-1:0]      cfg_wdata
);

  localparam int CB = COORD_BITS;
  localparam int DW = CB + 1;

  cfg_t                    cfg;
  stage_en_t               stg;
  logic [CNT_W-1:0]        cnt;
  logic [NUM_STG-1:0]      vld_r, vld_nxt, rdy, src;
  logic [TAG_W-1:0]        tag_r [NUM_STG];
  logic signed [CB-1:0]    pt [3];
  logic signed [CB-1:0]    vco [MAX_VERTICES][3];
  logic signed [CB-1:0]    nrm [3];
  logic signed [DW-1:0]    dif_r [MAX_VERTICES][3];
  logic signed [DW-1:0]    dif_nxt [MAX_VERTICES][3];
  logic signed [DW-1:0]    b_sel [MAX_VERTICES][3];
  logic [MAX_VERTICES-1:0] pos, neg, act;
  logic                    inside_r, inside_nxt;

  pif_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  // clamp vertex count to the supported range
  always_comb begin
    if (cfg.vertex_count < MIN_VERTICES)
      cnt = MIN_VERTICES;
    else if (cfg.vertex_count > CNT_W'(MAX_VERTICES))
      cnt = CNT_W'(MAX_VERTICES);
    else
      cnt = cfg.vertex_count;
  end

  // ready chain and valid bits
  always_comb begin
    rdy[NUM_STG-1] = !vld_r[NUM_STG-1] || out_ch.ready;
    for (int s = NUM_STG - 2; s >= 0; s--) begin
      rdy[s] = !vld_r[s] || rdy[s+1];
    end
    src[0] = in_ch.valid;
    for (int s = 1; s < NUM_STG; s++) begin
      src[s] = vld_r[s-1];
    end
    stg.en  = rdy & src;
    vld_nxt = (rdy & src) | (~rdy & vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= vld_nxt;
  end

  // stage 0: vertex minus point
  always_comb begin
    pt[0] = in_ch.point_x[CB-1:0];
    pt[1] = in_ch.point_y[CB-1:0];
    pt[2] = in_ch.point_z[CB-1:0];
    for (int k = 0; k < 3; k++) begin
      nrm[k] = cfg.normal[k*CB +: CB];
    end
    for (int v = 0; v < MAX_VERTICES; v++) begin
      for (int k = 0; k < 3; k++) begin
        vco[v][k]     = cfg.vtx[v][k*CB +: CB];
        dif_nxt[v][k] = DW'(vco[v][k]) - DW'(pt[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stg.en[0]) dif_r <= dif_nxt;
  end

  // edge lanes; the last edge in use wraps back to vertex 0
  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_lane
    localparam int JN = (i + 1) % MAX_VERTICES;

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        b_sel[i][k] = (CNT_W'(i + 1) >= cnt) ? dif_r[0][k] : dif_r[JN][k];
      end
      act[i] = CNT_W'(i) < cnt;
    end

    pif_edge_lane #(.CB(CB)) u_lane (
      .clk   (clk),
      .stg   (stg),
      .a_i   (dif_r[i]),
      .b_i   (b_sel[i]),
      .n_i   (nrm),
      .pos_o (pos[i]),
      .neg_o (neg[i])
    );
  end

  // stage 6: combine edge signs
  assign inside_nxt = (&(pos | ~act)) | (&(neg | ~act));

  always_ff @(posedge clk) begin
    if (stg.en[0]) tag_r[0] <= in_ch.node_tag;
    for (int s = 1; s < NUM_STG; s++) begin
      if (stg.en[s]) tag_r[s] <= tag_r[s-1];
    end
    if (stg.en[NUM_STG-1]) inside_r <= inside_nxt;
  end

  assign in_ch.ready       = rdy[0];
  assign out_ch.valid      = vld_r[NUM_STG-1];
  assign out_ch.inside_res = inside_r;
  assign out_ch.tag_out    = tag_r[NUM_STG-1];

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (&vld_r) && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while pipeline full and stalled");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> vld_r[0])
    else $error("accepted word lost at stage 0");

  a_sign_cover: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NUM_STG-2] |-> &(pos | neg))
    else $error("edge term has neither sign");

endmodule

`default_nettype wire

// ----- rtl/core/pif_cfg_regs.sv -----
// Configuration register file: vertex count, vertex coordinates, face normal.
`default_nettype none

module pif_cfg_regs import pif_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [REG_W-1:0]      cfg_wdata,
  output cfg_t                  cfg_o
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.vertex_count <= VCOUNT_RST;
      cfg_r.vtx          <= '0;
      cfg_r.normal       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_VERTEX_COUNT: cfg_r.vertex_count <= cfg_wdata[CNT_W-1:0];
        CFG_VERTEX0:      cfg_r.vtx[0]       <= cfg_wdata;
        CFG_VERTEX1:      cfg_r.vtx[1]       <= cfg_wdata;
        CFG_VERTEX2:      cfg_r.vtx[2]       <= cfg_wdata;
        CFG_VERTEX3:      cfg_r.vtx[3]       <= cfg_wdata;
        CFG_NORMAL:       cfg_r.normal       <= cfg_wdata;
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

`default_nettype wire

// ----- rtl/core/pif_edge_lane.sv -----
// One edge of the face: cross product, dot with normal, sign flags (stages 1-5).
`default_nettype none

module pif_edge_lane import pif_pkg::*; #(
  parameter int CB = 21
) (
  input  logic                 clk,
  input  stage_en_t            stg,
  input  logic signed [CB:0]   a_i [3],   // V_i - p
  input  logic signed [CB:0]   b_i [3],   // V_j - p
  input  logic signed [CB-1:0] n_i [3],   // face normal
  output logic                 pos_o,     // term >= 0
  output logic                 neg_o      // term <= 0
);

  localparam int DW    = CB + 1;
  localparam int PW    = 2 * DW;
  localparam int CW    = PW + 1;
  localparam int SPLIT = (CW + 1) / 2;
  localparam int HW    = CW - SPLIT;
  localparam int NHW   = CB + HW;
  localparam int NLW   = CB + SPLIT + 1;
  localparam int HSW   = NHW + 2;
  localparam int LSW   = NLW + 2;
  localparam int TW    = CB + CW + 3;

  logic signed [PW-1:0]    prod_r [6];
  logic signed [PW-1:0]    prod_nxt [6];
  logic signed [CW-1:0]    c_r [3];
  logic signed [CW-1:0]    c_nxt [3];
  logic signed [HW-1:0]    ch [3];
  logic signed [SPLIT:0]   cl [3];
  logic signed [NHW-1:0]   nh_r [3];
  logic signed [NHW-1:0]   nh_nxt [3];
  logic signed [NLW-1:0]   nl_r [3];
  logic signed [NLW-1:0]   nl_nxt [3];
  logic signed [HSW-1:0]   hs_r, hs_nxt;
  logic signed [LSW-1:0]   ls_r, ls_nxt;
  logic signed [TW-1:0]    total;
  logic                    pos_r, pos_nxt, neg_r, neg_nxt;

  always_comb begin
    prod_nxt[0] = PW'(a_i[1]) * PW'(b_i[2]);
    prod_nxt[1] = PW'(a_i[2]) * PW'(b_i[1]);
    prod_nxt[2] = PW'(a_i[2]) * PW'(b_i[0]);
    prod_nxt[3] = PW'(a_i[0]) * PW'(b_i[2]);
    prod_nxt[4] = PW'(a_i[0]) * PW'(b_i[1]);
    prod_nxt[5] = PW'(a_i[1]) * PW'(b_i[0]);

    for (int k = 0; k < 3; k++) begin
      c_nxt[k] = CW'(prod_r[2*k]) - CW'(prod_r[2*k+1]);
    end

    // split the cross term so each normal product stays narrow
    for (int k = 0; k < 3; k++) begin
      ch[k]     = c_r[k][CW-1:SPLIT];
      cl[k]     = {1'b0, c_r[k][SPLIT-1:0]};
      nh_nxt[k] = NHW'(n_i[k]) * NHW'(ch[k]);
      nl_nxt[k] = NLW'(n_i[k]) * NLW'(cl[k]);
    end

    hs_nxt = HSW'(nh_r[0]) + HSW'(nh_r[1]) + HSW'(nh_r[2]);
    ls_nxt = LSW'(nl_r[0]) + LSW'(nl_r[1]) + LSW'(nl_r[2]);

    total   = (TW'(hs_r) <<< SPLIT) + TW'(ls_r);
    pos_nxt = ~total[TW-1];
    neg_nxt = total[TW-1] | (total == '0);
  end

  always_ff @(posedge clk) begin
    if (stg.en[1]) prod_r <= prod_nxt;
    if (stg.en[2]) c_r    <= c_nxt;
    if (stg.en[3]) begin
      nh_r <= nh_nxt;
      nl_r <= nl_nxt;
    end
    if (stg.en[4]) begin
      hs_r <= hs_nxt;
      ls_r <= ls_nxt;
    end
    if (stg.en[5]) begin
      pos_r <= pos_nxt;
      neg_r <= neg_nxt;
    end
  end

  assign pos_o = pos_r;
  assign neg_o = neg_r;

endmodule

`default_nettype wire

// ----- sim/point_in_face_test_test.sv -----
// Testbench for point_in_face_test: random faces and points checked against an exact predictor.
`timescale 1ns / 100ps

module point_in_face_test_test;
  import pif_pkg::*;

  localparam int MAX_VTX        = 4;
  localparam int COORD_MAX      = (1 << (PT_W - 1)) - 1;
  localparam int COORD_MIN      = -(1 << (PT_W - 1));
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = NUM_STG + 4;
  localparam int HOLD_CYCLES    = 120;
  localparam int RANDOM_PHASES  = 16;
  localparam int PHASE_ITEMS    = 105;
  localparam int REPORT_MAX     = 10;

  // indexes past the register map; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  typedef logic signed [PT_W-1:0] coord_t;
  typedef enum {FACE_QUAD, FACE_TRI, FACE_SEGMENT, FACE_NOISE} face_kind_t;

  class face_scoreboard;
    typedef struct {
      logic             in_face;
      logic [TAG_W-1:0] tag;
    } face_result_t;

    logic [CNT_W-1:0] vcount;
    logic [REG_W-1:0] vtx [NUM_VREGS];
    logic [REG_W-1:0] nrm;
    face_result_t     pending_q [$];
    int               errors;

    function new();
      vcount = VCOUNT_RST;
      foreach (vtx[i]) vtx[i] = '0;
      nrm    = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
      case (idx)
        CFG_VERTEX_COUNT: vcount = data[CNT_W-1:0];
        CFG_VERTEX0, CFG_VERTEX1, CFG_VERTEX2, CFG_VERTEX3: vtx[idx - CFG_VERTEX0] = data;
        CFG_NORMAL: nrm = data;
        default: ;
      endcase
    endfunction

    function coord_t coord(logic [REG_W-1:0] xyz, int k);
      return xyz[k*PT_W +: PT_W];
    endfunction

    // exact sign of N . ((Vi - p) x (Vj - p)) per edge, full-width products
    function void note_point(coord_t px, coord_t py, coord_t pz, logic [TAG_W-1:0] tag);
      coord_t                 pt [3];
      logic signed [PT_W:0]   a [3];
      logic signed [PT_W:0]   b [3];
      logic signed [47:0]     c [3];
      logic signed [71:0]     d;
      int                     cnt;
      int                     j;
      bit                     any_pos;
      bit                     any_neg;
      face_result_t           r;
      pt[0] = px;
      pt[1] = py;
      pt[2] = pz;
      any_pos = 0;
      any_neg = 0;
      cnt = int'(vcount);
      if (cnt < int'(MIN_VERTICES)) cnt = int'(MIN_VERTICES);
      if (cnt > MAX_VTX) cnt = MAX_VTX;
      for (int i = 0; i < cnt; i++) begin
        j = (i + 1 == cnt) ? 0 : i + 1;
        for (int k = 0; k < 3; k++) begin
          a[k] = coord(vtx[i], k) - pt[k];
          b[k] = coord(vtx[j], k) - pt[k];
        end
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
        d = coord(nrm, 0) * c[0] + coord(nrm, 1) * c[1] + coord(nrm, 2) * c[2];
        if (d > 0) any_pos = 1;
        if (d < 0) any_neg = 1;
      end
      r.in_face = !(any_pos && any_neg);
      r.tag     = tag;
      pending_q = {pending_q, r};
    endfunction

    function void check_result(logic in_face, logic [TAG_W-1:0] tag);
      face_result_t e;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("%0t: unexpected result word in_face=%b tag=%h", $realtime, in_face, tag);
        return;
      end
      e = pending_q.pop_front();
      if (in_face !== e.in_face || tag !== e.tag) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("%0t: mismatch: expected in_face=%b tag=%h, got in_face=%b tag=%h",
                   $realtime, e.in_face, e.tag, in_face, tag);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [REG_W-1:0]     cfg_wdata;

  pif_in_if  in_ch ();
  pif_out_if out_ch ();

  point_in_face_test i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  face_scoreboard sb = new();

  bit tx_burst;
  bit rx_burst;
  bit hold_req;
  int idle_cycles;

  // geometry of the loaded face, used to aim points at it
  int fv_x [MAX_VTX];
  int fv_y [MAX_VTX];
  int fv_z [MAX_VTX];
  int f_used;
  int f_span;
  int seg_dx, seg_dy, seg_dz;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int rand_coord();
    return int'($urandom_range(0, (1 << PT_W) - 1)) + COORD_MIN;
  endfunction

  function automatic int rand_offset(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic [REG_W-1:0] pack_xyz(int x, int y, int z);
    return {coord_t'(z), coord_t'(y), coord_t'(x)};
  endfunction

  // called at a falling edge, returns at the falling edge after the write
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_point(int px, int py, int pz, logic [TAG_W-1:0] tag);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.point_x  <= coord_t'(px);
    in_ch.point_y  <= coord_t'(py);
    in_ch.point_z  <= coord_t'(pz);
    in_ch.node_tag <= tag;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_point(coord_t'(px), coord_t'(py), coord_t'(pz), tag);
    @(negedge clk);
  endtask

  // stop offering, wait for every result word, then let the pipeline settle
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_face(face_kind_t kind);
    int cx, cy, cz, r, nx, ny, nz, cnt;
    cx = rand_offset(1 << (PT_W - 2));
    cy = rand_offset(1 << (PT_W - 2));
    cz = rand_offset(1 << (PT_W - 2));
    r  = $urandom_range(0, 1) ? $urandom_range(1, 64) : $urandom_range(1, 1 << (PT_W - 3));
    fv_x = '{cx + r, cx, cx - r, cx};
    fv_y = '{cy, cy + r, cy, cy - r};
    fv_z = '{cz, cz, cz, cz};
    f_span = r + r / 4 + 2;
    nx = rand_offset(32);
    ny = rand_offset(32);
    nz = $urandom_range(1, COORD_MAX);
    if ($urandom_range(0, 1)) nz = -nz;
    cnt = 4;
    case (kind)
      FACE_TRI: cnt = 3;
      FACE_SEGMENT: begin
        cnt = 2;
        seg_dx = rand_offset(64);
        seg_dy = rand_offset(64);
        seg_dz = rand_offset(64);
        if (seg_dx == 0 && seg_dy == 0 && seg_dz == 0) seg_dx = 1;
        fv_x[1] = cx + seg_dx;
        fv_y[1] = cy + seg_dy;
        fv_z[1] = cz + seg_dz;
        nx = rand_coord();
        ny = rand_coord();
        nz = rand_coord();
      end
      FACE_NOISE: begin
        cnt = $urandom_range(0, 7);
        for (int i = 0; i < MAX_VTX; i++) begin
          fv_x[i] = rand_coord();
          fv_y[i] = rand_coord();
          fv_z[i] = rand_coord();
        end
        nx = rand_coord();
        ny = rand_coord();
        nz = rand_coord();
      end
      default: ;
    endcase
    if ($urandom_range(0, 7) == 0) nz = COORD_MIN;
    if ($urandom_range(0, 7) == 0) begin
      nx = 0;
      ny = 0;
      nz = 0;
    end
    f_used = (cnt < 2) ? 2 : (cnt > MAX_VTX) ? MAX_VTX : cnt;
    cfg_write(CFG_VERTEX_COUNT, REG_W'(cnt));
    for (int i = 0; i < MAX_VTX; i++)
      cfg_write(CFG_IDX_W'(CFG_VERTEX0 + i), pack_xyz(fv_x[i], fv_y[i], fv_z[i]));
    cfg_write(CFG_NORMAL, pack_xyz(nx, ny, nz));
    if ($urandom_range(0, 3) == 0)
      cfg_write($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, REG_W'({$urandom, $urandom}));
  endtask

  task automatic run_phase(face_kind_t kind, int n);
    int px, py, pz, pick, v, w, t;
    for (int it = 0; it < n; it++) begin
      pick = $urandom_range(0, 99);
      v    = $urandom_range(0, f_used - 1);
      w    = (v + 1) % f_used;
      px   = rand_coord();
      py   = rand_coord();
      pz   = rand_coord();
      if (kind == FACE_SEGMENT && pick < 80) begin
        // points on the segment's line, half of them nudged off it
        t  = rand_offset(100);
        px = fv_x[0] + t * seg_dx;
        py = fv_y[0] + t * seg_dy;
        pz = fv_z[0] + t * seg_dz;
        if (pick < 40) px = px + 1;
      end else if (kind == FACE_QUAD || kind == FACE_TRI) begin
        if (pick < 55) begin
          px = fv_x[0] - f_span + 2 + rand_offset(f_span);
          py = fv_y[1] - f_span + 2 + rand_offset(f_span);
          pz = fv_z[0] + rand_offset(8);
          px = (fv_x[0] + fv_x[2]) / 2 + rand_offset(f_span);
          py = (fv_y[1] + fv_y[3]) / 2 + rand_offset(f_span);
        end else if (pick < 70) begin
          px = fv_x[v];
          py = fv_y[v];
          pz = fv_z[v];
        end else if (pick < 80) begin
          px = (fv_x[v] + fv_x[w]) / 2;
          py = (fv_y[v] + fv_y[w]) / 2;
          pz = (fv_z[v] + fv_z[w]) / 2;
        end
      end
      send_point(px, py, pz, TAG_W'($urandom_range(0, (1 << TAG_W) - 1)));
    end
  endtask

  initial begin
    face_kind_t kind;
    int         pick;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_VERTEX_COUNT;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.point_x  = '0;
    in_ch.point_y  = '0;
    in_ch.point_z  = '0;
    in_ch.node_tag = '0;
    tx_burst       = 1'b0;
    hold_req       = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset state: zero normal, so everything is inside
    send_point(COORD_MAX, COORD_MAX, COORD_MAX, 16'hffff);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN, 16'h0000);
    quiesce();

    // axis-aligned square in the z = 0 plane
    cfg_write(CFG_VERTEX0, pack_xyz(-1000, -1000, 0));
    cfg_write(CFG_VERTEX1, pack_xyz(1000, -1000, 0));
    cfg_write(CFG_VERTEX2, pack_xyz(1000, 1000, 0));
    cfg_write(CFG_VERTEX3, pack_xyz(-1000, 1000, 0));
    cfg_write(CFG_NORMAL, pack_xyz(0, 0, 1024));
    // would zero the normal or the count if the spare indexes were decoded
    cfg_write(CFG_SPARE_A, '0);
    cfg_write(CFG_SPARE_B, '0);
    send_point(0, 0, 0, 16'h1234);
    send_point(1000, 1000, 0, 16'h5678);
    send_point(1000, 0, 55, 16'h9abc);
    send_point(1001, 0, 0, 16'hdef0);
    send_point(COORD_MAX, COORD_MIN, COORD_MAX, 16'h8001);
    send_point(COORD_MIN, COORD_MAX, COORD_MIN, 16'h7ffe);
    quiesce();

    // face spanning the full coordinate range, extreme normal
    cfg_write(CFG_VERTEX0, pack_xyz(COORD_MIN, COORD_MIN, COORD_MIN));
    cfg_write(CFG_VERTEX1, pack_xyz(COORD_MAX, COORD_MIN, COORD_MAX));
    cfg_write(CFG_VERTEX2, pack_xyz(COORD_MAX, COORD_MAX, COORD_MIN));
    cfg_write(CFG_VERTEX3, pack_xyz(COORD_MIN, COORD_MAX, COORD_MAX));
    cfg_write(CFG_NORMAL, pack_xyz(COORD_MIN, COORD_MAX, COORD_MIN));
    send_point(0, 0, 0, 16'h0f0f);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX, 16'hf0f0);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN, 16'h3c3c);
    send_point(COORD_MAX, 0, COORD_MIN, 16'hc3c3);
    quiesce();
    cfg_write(CFG_VERTEX_COUNT, 3);
    send_point(0, 0, 0, 16'h0001);
    send_point(-5000, 1234, 99, 16'h0002);
    quiesce();

    // two-vertex face: inside only in the plane through both vertices that holds the normal direction
    cfg_write(CFG_VERTEX_COUNT, 2);
    cfg_write(CFG_VERTEX0, pack_xyz(0, 0, 0));
    cfg_write(CFG_VERTEX1, pack_xyz(10, 20, 30));
    cfg_write(CFG_NORMAL, pack_xyz(7, -3, 1));
    send_point(20, 40, 60, 16'h0003);
    send_point(5, 10, 15, 16'h0004);
    send_point(1, 0, 0, 16'h0005);
    quiesce();
    // counts below two and above four are clamped
    cfg_write(CFG_VERTEX_COUNT, 0);
    send_point(30, 60, 90, 16'h0006);
    send_point(3, 3, 3, 16'h0007);
    quiesce();
    cfg_write(CFG_VERTEX_COUNT, 7);
    send_point(rand_coord(), rand_coord(), rand_coord(), 16'h0008);
    send_point(10, 20, 31, 16'h0009);
    quiesce();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      pick = $urandom_range(0, 9);
      if (ph < 4) kind = face_kind_t'(ph);
      else kind = (pick < 4) ? FACE_QUAD : (pick < 7) ? FACE_TRI :
                  (pick < 9) ? FACE_SEGMENT : FACE_NOISE;
      tx_burst = ($urandom_range(0, 2) == 0);
      load_face(kind);
      if (ph == 2) begin
        // sender runs flat out while the receiver holds off
        tx_burst = 1'b1;
        hold_req = 1'b1;
      end
      run_phase(kind, PHASE_ITEMS);
      quiesce();
    end

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // result side: random stalls, burst stretches, and one long hold-off
  initial begin
    int stall;
    int n_rx;
    bit held;
    n_rx         = 0;
    held         = 1'b0;
    rx_burst     = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        held = 1'b1;
      end else begin
        stall = rx_burst ? 0 : $urandom_range(0, 8);
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      n_rx++;
      if (n_rx % 50 == 0) rx_burst = ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.inside_res, out_ch.tag_out);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
